>>> sv/anchor_decode_nms_defines.svh
// assertion macros for the anchor decode and suppression block
// used by the top level only; ASSERT_OFF removes every check
`ifndef ANCHOR_DECODE_NMS_DEFINES_SVH
`define ANCHOR_DECODE_NMS_DEFINES_SVH
`ifndef ASSERT_OFF
`define ADNMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ADNMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADNMS_ASSERT(lbl, prop, msg)
`define ADNMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/adnms_pkg.sv
// shared types and constants for the anchor decode and suppression block
// no dependencies
`default_nettype none
package adnms_pkg;

  localparam int FLD_W       = 16;
  localparam int IDX_W       = 12;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic [13:0] {
    ST_COLLECT = 14'b00000000000001,
    ST_WAIT    = 14'b00000000000010,
    ST_I_CHK   = 14'b00000000000100,
    ST_J_CHK   = 14'b00000000001000,
    ST_RD      = 14'b00000000010000,
    ST_P1      = 14'b00000000100000,
    ST_P2      = 14'b00000001000000,
    ST_P3      = 14'b00000010000000,
    ST_DEC     = 14'b00000100000000,
    ST_E_CHK   = 14'b00001000000000,
    ST_E_RD    = 14'b00010000000000,
    ST_E_LD    = 14'b00100000000000,
    ST_E_NONE  = 14'b01000000000000,
    ST_CLEAR   = 14'b10000000000000
  } adnms_state_t;

  typedef struct packed {
    logic accept_en;
    logic i_clr;
    logic i_inc;
    logic j_set;
    logic j_inc;
    logic drop_i;
    logic drop_j;
    logic load_box;
    logic load_none;
    logic frame_clr;
  } adnms_cmd_t;

  typedef struct packed {
    logic fin_acc;
    logic i_end;
    logic j_end;
    logic kept_i;
    logic kept_j;
    logic overlap;
    logic score_lt;
    logic any_kept;
    logic last_i;
    logic out_free;
  } adnms_sts_t;

endpackage
`default_nettype wire

>>> sv/anchor_decode_nms.sv
// Anchor decode with IoU non-maximum suppression. Anchors are taken one beat
// per cycle while collecting; those whose logit reaches the threshold are
// decoded and stored (up to MAX_CANDIDATES, more set the overflow flag). The
// beat with tlast closes the frame: input stalls while a shared IoU unit
// compares each kept pair in index order, then each surviving box is sent.
// The frame ends with a tlast beat; if nothing survived a single beat with
// tuser[0] low is sent. Depends on adnms_pkg, adnms_ctrl, adnms_dp, adnms_ram.
`default_nettype none
`include "anchor_decode_nms_defines.svh"
module anchor_decode_nms #(
  parameter int MAX_CANDIDATES = 32,
  parameter int COORD_BITS     = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [15:0]  cfg_wr_data,   // min_score
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,      // anchor_cx, anchor_cy, offset_x, offset_y,
                                           // size_w, size_h, logit
  input  wire logic         in_tlast,      // final_anchor
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [95:0]  out_tdata,     // anchor_index, box_cx, box_cy, box_w,
                                           // box_h, box_score, zero pad
  output logic      [1:0]   out_tuser,     // valid_res, overflow
  output logic              out_tlast      // last
);
  adnms_pkg::adnms_cmd_t cmd;
  adnms_pkg::adnms_sts_t sts;

  adnms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd)
  );

  adnms_dp #(.MAX_CANDIDATES(MAX_CANDIDATES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast), .cmd(cmd), .sts(sts)
  );

  assign in_tready = cmd.accept_en;

  `ADNMS_ASSERT(a_empty_is_last, out_tvalid && !out_tuser[0] |-> out_tlast, "empty beat without tlast")
  `ADNMS_ASSERT(a_stall_after_final, in_tvalid && in_tready && in_tlast |=> !in_tready, "input taken after frame end")
  `ADNMS_ASSERT(a_no_input_midframe, out_tvalid && !out_tlast |-> !in_tready, "input open during emission")
endmodule
`default_nettype wire

>>> sv/adnms_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module adnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]             rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

>>> sv/adnms_ctrl.sv
// controller: collection, pairwise suppression sequencing and emission
// depends on adnms_pkg
`default_nettype none
module adnms_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire adnms_pkg::adnms_sts_t sts,
  output adnms_pkg::adnms_cmd_t    cmd
);
  adnms_pkg::adnms_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= adnms_pkg::ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      adnms_pkg::ST_COLLECT: begin
        cmd.accept_en = 1'b1;
        if (sts.fin_acc) begin
          cmd.i_clr = 1'b1;
          state_nxt = adnms_pkg::ST_WAIT;
        end
      end
      adnms_pkg::ST_WAIT: state_nxt = adnms_pkg::ST_I_CHK;
      adnms_pkg::ST_I_CHK: begin
        if (sts.i_end) begin
          cmd.i_clr = 1'b1;
          state_nxt = sts.any_kept ? adnms_pkg::ST_E_CHK : adnms_pkg::ST_E_NONE;
        end else if (!sts.kept_i) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.j_set = 1'b1;
          state_nxt = adnms_pkg::ST_J_CHK;
        end
      end
      adnms_pkg::ST_J_CHK: begin
        if (sts.j_end) begin
          cmd.i_inc = 1'b1;
          state_nxt = adnms_pkg::ST_I_CHK;
        end else if (!sts.kept_j) begin
          cmd.j_inc = 1'b1;
        end else begin
          state_nxt = adnms_pkg::ST_RD;
        end
      end
      adnms_pkg::ST_RD: state_nxt = adnms_pkg::ST_P1;
      adnms_pkg::ST_P1: state_nxt = adnms_pkg::ST_P2;
      adnms_pkg::ST_P2: state_nxt = adnms_pkg::ST_P3;
      adnms_pkg::ST_P3: state_nxt = adnms_pkg::ST_DEC;
      adnms_pkg::ST_DEC: begin
        if (sts.overlap && sts.score_lt) begin
          cmd.drop_i = 1'b1;
          cmd.i_inc  = 1'b1;
          state_nxt  = adnms_pkg::ST_I_CHK;
        end else begin
          cmd.drop_j = sts.overlap;
          cmd.j_inc  = 1'b1;
          state_nxt  = adnms_pkg::ST_J_CHK;
        end
      end
      adnms_pkg::ST_E_CHK: begin
        if (sts.i_end) begin
          state_nxt = adnms_pkg::ST_CLEAR;
        end else if (!sts.kept_i) begin
          cmd.i_inc = 1'b1;
        end else begin
          state_nxt = adnms_pkg::ST_E_RD;
        end
      end
      adnms_pkg::ST_E_RD: state_nxt = adnms_pkg::ST_E_LD;
      adnms_pkg::ST_E_LD: begin
        if (sts.out_free) begin
          cmd.load_box = 1'b1;
          if (sts.last_i) begin
            state_nxt = adnms_pkg::ST_CLEAR;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = adnms_pkg::ST_E_CHK;
          end
        end
      end
      adnms_pkg::ST_E_NONE: begin
        if (sts.out_free) begin
          cmd.load_none = 1'b1;
          state_nxt     = adnms_pkg::ST_CLEAR;
        end
      end
      adnms_pkg::ST_CLEAR: begin
        cmd.frame_clr = 1'b1;
        state_nxt     = adnms_pkg::ST_COLLECT;
      end
      default: state_nxt = adnms_pkg::ST_COLLECT;
    endcase
  end
endmodule
`default_nettype wire

>>> sv/adnms_dp.sv
// datapath: decode stage, candidate stores, iou unit, kept flags, output register
// depends on adnms_pkg and adnms_ram
`default_nettype none
module adnms_dp #(
  parameter int MAX_CANDIDATES = 32,
  parameter int COORD_BITS     = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [adnms_pkg::FLD_W-1:0]           cfg_wr_data,
  input  wire logic                                  in_tvalid,
  input  wire logic [adnms_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire logic                                  in_tlast,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic      [adnms_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic      [adnms_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                       out_tlast,
  input  wire adnms_pkg::adnms_cmd_t                 cmd,
  output adnms_pkg::adnms_sts_t                      sts
);
  localparam int MC  = MAX_CANDIDATES;
  localparam int CB  = COORD_BITS;
  localparam int FW  = adnms_pkg::FLD_W;
  localparam int XW_ = adnms_pkg::IDX_W;
  localparam int AW  = (MC > 1) ? $clog2(MC) : 1;
  localparam int NW  = $clog2(MC + 1);
  localparam int SW  = ((CB > 17) ? CB : 17) + 1;
  localparam int OW  = (CB > FW) ? CB : FW;
  localparam int CW  = OW + 3;
  localparam int PW  = 2 * CW;
  localparam int QW  = PW + 4;
  localparam int EW  = 2 * CB + 92;
  localparam int O_W = 2 * CB;
  localparam int O_H = 2 * CB + 16;
  localparam int O_A = 2 * CB + 32;
  localparam int O_S = 2 * CB + 64;
  localparam int O_I = 2 * CB + 80;

  logic signed [FW-1:0]  thr_r;
  logic                  st_vld_r;
  logic [adnms_pkg::IN_TDATA_W-1:0] st_d_r;
  logic [NW-1:0]         cnt_r;
  logic [XW_-1:0]        acnt_r;
  logic                  ovf_r;
  logic [MC-1:0]         kept_r;
  logic [NW-1:0]         i_r, j_r;
  logic                  acc, thr_ok, we;
  logic signed [SW-1:0]  sum_x, sum_y, sat_hi, sat_lo;
  logic signed [CB-1:0]  cx_w, cy_w;
  logic signed [31:0]    area_w;
  logic [EW-1:0]         wdata, qa, qb;

  assign acc = in_tvalid && cmd.accept_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= 1'b0;
    end else begin
      st_vld_r <= acc;
    end
    if (acc) begin
      st_d_r <= in_tdata;
    end
  end

  // decode and saturate the centers
  always_comb begin
    sat_hi = SW'((64'sd1 <<< (CB - 1)) - 64'sd1);
    sat_lo = -sat_hi - SW'(1);
    sum_x  = SW'($signed(st_d_r[15:0])) + SW'($signed(st_d_r[47:32]));
    sum_y  = SW'($signed(st_d_r[31:16])) + SW'($signed(st_d_r[63:48]));
    cx_w   = (sum_x > sat_hi) ? CB'(sat_hi) : (sum_x < sat_lo) ? CB'(sat_lo) : CB'(sum_x);
    cy_w   = (sum_y > sat_hi) ? CB'(sat_hi) : (sum_y < sat_lo) ? CB'(sat_lo) : CB'(sum_y);
    area_w = 32'($signed(st_d_r[79:64]) * $signed(st_d_r[95:80]));
    thr_ok = $signed(st_d_r[111:96]) >= thr_r;
    we     = st_vld_r && thr_ok && (cnt_r < NW'(MC));
    wdata  = {acnt_r, st_d_r[111:96], area_w, st_d_r[95:80], st_d_r[79:64], cy_w, cx_w};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      acnt_r <= '0;
      ovf_r  <= 1'b0;
      kept_r <= '0;
    end else if (cmd.frame_clr) begin
      cnt_r  <= '0;
      acnt_r <= '0;
      ovf_r  <= 1'b0;
      kept_r <= '0;
    end else begin
      if (st_vld_r) begin
        acnt_r <= acnt_r + XW_'(1);
        if (we) begin
          cnt_r               <= cnt_r + NW'(1);
          kept_r[cnt_r[AW-1:0]] <= 1'b1;
        end else if (thr_ok) begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.drop_i) begin
        kept_r[i_r[AW-1:0]] <= 1'b0;
      end
      if (cmd.drop_j) begin
        kept_r[j_r[AW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else begin
      if (cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + NW'(1);
      end
      if (cmd.j_set) begin
        j_r <= i_r + NW'(1);
      end else if (cmd.j_inc) begin
        j_r <= j_r + NW'(1);
      end
    end
  end

  adnms_ram #(.WIDTH(EW), .DEPTH(MC)) u_ram_a (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata(wdata),
    .raddr(i_r[AW-1:0]), .rdata(qa)
  );

  adnms_ram #(.WIDTH(EW), .DEPTH(MC)) u_ram_b (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata(wdata),
    .raddr(j_r[AW-1:0]), .rdata(qb)
  );

  // iou unit: corners and overlap extents
  logic signed [CW-1:0] ax1, ax2, ay1, ay2, bx1, bx2, by1, by2;
  logic signed [CW:0]   dx, dy;
  logic [CW-1:0]        ix_r, iy_r;
  logic signed [32:0]   asum_r, asum2_r;
  logic                 slt_r, pos_r, ovl_r;
  logic [PW-1:0]        prod_r;
  logic signed [QW-1:0] lhs, rhs;

  always_comb begin
    ax1 = (CW'($signed(qa[CB-1:0])) <<< 1) - CW'($signed(qa[O_W+15:O_W]));
    ax2 = (CW'($signed(qa[CB-1:0])) <<< 1) + CW'($signed(qa[O_W+15:O_W]));
    ay1 = (CW'($signed(qa[2*CB-1:CB])) <<< 1) - CW'($signed(qa[O_H+15:O_H]));
    ay2 = (CW'($signed(qa[2*CB-1:CB])) <<< 1) + CW'($signed(qa[O_H+15:O_H]));
    bx1 = (CW'($signed(qb[CB-1:0])) <<< 1) - CW'($signed(qb[O_W+15:O_W]));
    bx2 = (CW'($signed(qb[CB-1:0])) <<< 1) + CW'($signed(qb[O_W+15:O_W]));
    by1 = (CW'($signed(qb[2*CB-1:CB])) <<< 1) - CW'($signed(qb[O_H+15:O_H]));
    by2 = (CW'($signed(qb[2*CB-1:CB])) <<< 1) + CW'($signed(qb[O_H+15:O_H]));
    dx  = (CW+1)'((ax2 < bx2) ? ax2 : bx2) - (CW+1)'((ax1 > bx1) ? ax1 : bx1);
    dy  = (CW+1)'((ay2 < by2) ? ay2 : by2) - (CW+1)'((ay1 > by1) ? ay1 : by1);
    lhs = QW'(prod_r) + (QW'(prod_r) <<< 1);
    rhs = QW'(asum2_r) <<< 2;
  end

  always_ff @(posedge clk) begin
    ix_r    <= (dx > 0) ? dx[CW-1:0] : '0;
    iy_r    <= (dy > 0) ? dy[CW-1:0] : '0;
    asum_r  <= 33'($signed(qa[O_A+31:O_A])) + 33'($signed(qb[O_A+31:O_A]));
    slt_r   <= $signed(qa[O_S+15:O_S]) < $signed(qb[O_S+15:O_S]);
    prod_r  <= ix_r * iy_r;
    pos_r   <= (ix_r != '0) && (iy_r != '0);
    asum2_r <= asum_r;
    ovl_r   <= pos_r && (lhs > rhs);
  end

  // output register
  logic                         ov_r, ol_r;
  logic [adnms_pkg::OUT_TDATA_W-1:0] od_r;
  logic [adnms_pkg::OUT_TUSER_W-1:0] ou_r;
  logic signed [OW-1:0]         ocx, ocy;

  assign ocx = OW'($signed(qa[CB-1:0]));
  assign ocy = OW'($signed(qa[2*CB-1:CB]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load_box || cmd.load_none) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
    if (cmd.load_box) begin
      od_r <= {4'b0, qa[O_S+15:O_S], qa[O_H+15:O_H], qa[O_W+15:O_W],
               ocy[15:0], ocx[15:0], qa[O_I+11:O_I]};
      ou_r <= {ovf_r, 1'b1};
      ol_r <= sts.last_i;
    end else if (cmd.load_none) begin
      od_r <= '0;
      ou_r <= {ovf_r, 1'b0};
      ol_r <= 1'b1;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  always_comb begin
    sts.fin_acc  = acc && in_tlast;
    sts.i_end    = i_r >= cnt_r;
    sts.j_end    = j_r >= cnt_r;
    sts.kept_i   = !sts.i_end && kept_r[i_r[AW-1:0]];
    sts.kept_j   = !sts.j_end && kept_r[j_r[AW-1:0]];
    sts.overlap  = ovl_r;
    sts.score_lt = slt_r;
    sts.any_kept = |kept_r;
    sts.last_i   = ((kept_r >> i_r) >> 1) == '0;
    sts.out_free = !ov_r || out_tready;
  end
endmodule
`default_nettype wire

>>> sim/anchor_decode_nms_tb.sv
// testbench for anchor_decode_nms: streams anchor frames, predicts the kept boxes
// with its own decode and suppression model and checks every output beat
// depends on the anchor_decode_nms top level
`default_nettype none
module anchor_decode_nms_tb;

  localparam int NCAND    = 32;
  localparam int WDOG_MAX = 20000;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] anchor_index;
    logic [15:0] box_cx;
    logic [15:0] box_cy;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [15:0] box_score;
    logic        overflow;
    logic        last;
  } box_beat_t;

  typedef struct packed {
    logic [15:0] anchor_cx;
    logic [15:0] anchor_cy;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
    logic [15:0] size_w;
    logic [15:0] size_h;
    logic [15:0] logit;
    logic        final_anchor;
  } anchor_t;

  class nms_scoreboard;
    box_beat_t   kept_q[$];
    int          errors;
    logic signed [15:0] thresh;
    int          cand_cx[NCAND], cand_cy[NCAND], cand_w[NCAND], cand_h[NCAND];
    int          cand_score[NCAND];
    logic [11:0] cand_idx[NCAND];
    bit          kept[NCAND];
    int          n_cand;
    logic [11:0] anchor_cnt;
    bit          ovf;

    function new();
      errors = 0; thresh = 0; n_cand = 0; anchor_cnt = 0; ovf = 0;
    endfunction

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function bit boxes_overlap(int a, int b);
      longint ax1, ax2, ay1, ay2, bx1, bx2, by1, by2, ix, iy, inter, ar_a, ar_b;
      ax1 = 2 * longint'(cand_cx[a]) - cand_w[a]; ax2 = 2 * longint'(cand_cx[a]) + cand_w[a];
      ay1 = 2 * longint'(cand_cy[a]) - cand_h[a]; ay2 = 2 * longint'(cand_cy[a]) + cand_h[a];
      bx1 = 2 * longint'(cand_cx[b]) - cand_w[b]; bx2 = 2 * longint'(cand_cx[b]) + cand_w[b];
      by1 = 2 * longint'(cand_cy[b]) - cand_h[b]; by2 = 2 * longint'(cand_cy[b]) + cand_h[b];
      ix = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1);
      iy = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1);
      if (ix < 0) ix = 0;
      if (iy < 0) iy = 0;
      inter = ix * iy;
      ar_a = 4 * longint'(cand_w[a]) * cand_h[a];
      ar_b = 4 * longint'(cand_w[b]) * cand_h[b];
      if (inter <= 0) return 0;
      return 3 * inter > ar_a + ar_b;
    endfunction

    function void note_anchor(anchor_t a);
      box_beat_t r;
      int last_k;
      if ($signed(a.logit) >= thresh) begin
        if (n_cand < NCAND) begin
          cand_cx[n_cand]    = clamp16(int'($signed(a.anchor_cx)) + int'($signed(a.offset_x)));
          cand_cy[n_cand]    = clamp16(int'($signed(a.anchor_cy)) + int'($signed(a.offset_y)));
          cand_w[n_cand]     = int'($signed(a.size_w));
          cand_h[n_cand]     = int'($signed(a.size_h));
          cand_score[n_cand] = int'($signed(a.logit));
          cand_idx[n_cand]   = anchor_cnt;
          kept[n_cand]       = 1;
          n_cand++;
        end else ovf = 1;
      end
      anchor_cnt++;
      if (!a.final_anchor) return;
      for (int i = 0; i < n_cand; i++) begin
        if (!kept[i]) continue;
        for (int j = i + 1; j < n_cand; j++) begin
          if (!kept[j] || !boxes_overlap(i, j)) continue;
          if (cand_score[i] < cand_score[j]) begin
            kept[i] = 0;
            break;
          end
          kept[j] = 0;
        end
      end
      last_k = -1;
      for (int i = 0; i < n_cand; i++) if (kept[i]) last_k = i;
      if (last_k < 0) begin
        r = '0;
        r.overflow = ovf;
        r.last = 1;
        kept_q.push_back(r);
      end else begin
        for (int i = 0; i < n_cand; i++) begin
          if (!kept[i]) continue;
          r.valid_res    = 1;
          r.anchor_index = cand_idx[i];
          r.box_cx       = cand_cx[i][15:0];
          r.box_cy       = cand_cy[i][15:0];
          r.box_w        = cand_w[i][15:0];
          r.box_h        = cand_h[i][15:0];
          r.box_score    = cand_score[i][15:0];
          r.overflow     = ovf;
          r.last         = (i == last_k);
          kept_q.push_back(r);
        end
      end
      for (int i = 0; i < NCAND; i++) kept[i] = 0;
      n_cand = 0; anchor_cnt = 0; ovf = 0;
    endfunction

    function void check_beat(box_beat_t got);
      box_beat_t exp_b;
      if (kept_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_b = kept_q.pop_front();
      if (got !== exp_b) begin
        $display("%0t: mismatch, expected %h actual %h", $realtime, exp_b, got);
        errors++;
      end
    endfunction
  endclass

  logic         clk, rst_n;
  logic         cfg_wr_en;
  logic [15:0]  cfg_wr_data;
  logic         in_tvalid, in_tready, in_tlast;
  logic [111:0] in_tdata;
  logic         out_tvalid, out_tready, out_tlast;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;

  nms_scoreboard sb;
  int  watchdog;
  bit  hold_long;

  anchor_decode_nms u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // output side: check and count idle cycles
  always @(posedge clk) begin
    box_beat_t b;
    if (rst_n && out_tvalid && out_tready) begin
      b.valid_res    = out_tuser[0];
      b.overflow     = out_tuser[1];
      b.anchor_index = out_tdata[11:0];
      b.box_cx       = out_tdata[27:12];
      b.box_cy       = out_tdata[43:28];
      b.box_w        = out_tdata[59:44];
      b.box_h        = out_tdata[75:60];
      b.box_score    = out_tdata[91:76];
      b.last         = out_tlast;
      sb.check_beat(b);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) watchdog <= 0;
    else watchdog <= watchdog + 1;
  end

  always @(posedge clk) begin
    if (watchdog >= WDOG_MAX) begin
      $display("anchor_decode_nms verification failed");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_long = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap == 0) out_tready <= 1'b1;
      else begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_tready <= 1'b1;
      end
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  task automatic send_anchor(anchor_t a, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {a.logit, a.size_h, a.size_w, a.offset_y, a.offset_x, a.anchor_cy, a.anchor_cx};
    in_tlast  <= a.final_anchor;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_anchor(a);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.kept_q.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_thresh(logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.thresh = v;
  endtask

  function automatic anchor_t rand_anchor(bit fin, bit cluster);
    anchor_t a;
    a = 113'({$urandom, $urandom, $urandom, $urandom});
    if (cluster) begin
      a.anchor_cx = 16'($urandom_range(0, 255) << 4);
      a.anchor_cy = 16'($urandom_range(0, 255) << 4);
      a.offset_x  = 16'($signed($urandom_range(0, 64)) - 32);
      a.offset_y  = 16'($signed($urandom_range(0, 64)) - 32);
      a.size_w    = 16'($urandom_range(200, 1200));
      a.size_h    = 16'($urandom_range(200, 1200));
    end
    a.final_anchor = fin;
    return a;
  endfunction

  task automatic send_frame(int n, bit cluster, bit fast);
    anchor_t a;
    anchor_t base;
    base = rand_anchor(0, 1);
    for (int k = 0; k < n; k++) begin
      a = rand_anchor(k == n - 1, cluster);
      if (cluster && $urandom_range(0, 1)) begin
        a.anchor_cx = base.anchor_cx; a.anchor_cy = base.anchor_cy;
        a.size_w = base.size_w; a.size_h = base.size_h;
        if ($urandom_range(0, 3) == 0) a.logit = base.logit;
      end
      send_anchor(a, fast);
    end
  endtask

  initial begin
    anchor_t a;
    sb = new();
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    watchdog = 0; hold_long = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, empty frame, identical boxes with tie, negative sizes
    a = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, 1'b0};
    send_anchor(a, 0);
    a = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 1'b0};
    send_anchor(a, 0);
    a = '{16'h0100, 16'h0100, 16'h0, 16'h0, 16'h0400, 16'h0400, 16'h0200, 1'b0};
    send_anchor(a, 0);
    a = '{16'h0100, 16'h0100, 16'h0, 16'h0, 16'h0400, 16'h0400, 16'h0200, 1'b0};
    send_anchor(a, 0);
    a = '{16'h0104, 16'h0100, 16'h0, 16'h0, 16'h0400, 16'h0400, 16'h0300, 1'b0};
    send_anchor(a, 0);
    a = '{16'h0100, 16'h0100, 16'h0, 16'h0, 16'hfc00, 16'hfc00, 16'h0100, 1'b0};
    send_anchor(a, 0);
    a = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff, 1'b1};
    send_anchor(a, 0);
    wait_drained();
    // frame with nothing kept
    a = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 1'b1};
    send_anchor(a, 0);
    wait_drained();
    // lowest threshold keeps all: overflow with 36 anchors
    write_thresh(16'h8000);
    send_frame(36, 0, 1);
    wait_drained();
    write_thresh(16'h7fff);
    send_frame(3, 0, 0);
    wait_drained();

    // random frames at several thresholds, long output hold-off on one
    for (int f = 0; f < 14; f++) begin
      if (f % 4 == 0) begin
        wait_drained();
        write_thresh((f == 4) ? 16'h0 : 16'($signed($urandom_range(0, 512)) - 256));
      end
      if (f == 6) begin
        hold_long = 1;
        send_frame(6, 1, 1);
        send_frame(5, 1, 1);
      end else send_frame($urandom_range(2, 14), $urandom_range(0, 3) != 0,
                          $urandom_range(0, 4) == 0);
    end
    wait_drained();

    if (sb.errors == 0) $display("anchor_decode_nms verification clean");
    else $display("anchor_decode_nms verification failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> anchor_decode_nms.f
+incdir+sv
sv/adnms_pkg.sv
sv/adnms_ram.sv
sv/adnms_ctrl.sv
sv/adnms_dp.sv
sv/anchor_decode_nms.sv
sim/anchor_decode_nms_tb.sv
